/* sv/dpb_pkg.sv */
// ----------------------------------------------------------------------------
// dpb_pkg
// Types, codes and constants shared by the picture buffer bumping logic.
// ----------------------------------------------------------------------------
package dpb_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	// command codes
	localparam logic [2:0] CMD_WRITE   = 3'd0;
	localparam logic [2:0] CMD_ALLOC   = 3'd1;
	localparam logic [2:0] CMD_SELECT  = 3'd2;
	localparam logic [2:0] CMD_RELEASE = 3'd3;
	localparam logic [2:0] CMD_CLOSEST = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// progress levels
	localparam logic [2:0] PR_RECON    = 3'd4;
	localparam logic [2:0] PR_FINISHED = 3'd5;

	// flag bit positions
	localparam int FL_NEEDED = 0;
	localparam int FL_REF    = 1;
	localparam int FL_STILL  = 2;
	localparam int FL_IDR    = 3;
	localparam int FL_LOCK   = 4;

	// register indexes
	localparam logic [1:0] CFG_FRAME_DELAY = 2'd0;
	localparam logic [1:0] CFG_PARALLEL    = 2'd1;
	localparam logic [1:0] CFG_SLACK       = 2'd2;

	localparam logic [32:0] DIST_INIT = 33'h0_7FFF_FFFF;

	typedef struct packed {
		logic [2:0]         command;
		logic [4:0]         slot;
		logic signed [31:0] poc_value;
		logic [2:0]         progress;
		logic               needed_for_output;
		logic               reference_marked;
		logic               still_referenced;
		logic               idr_start;
		logic [4:0]         num_reorder;
		logic               flush;
		logic [5:0]         max_pictures;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         result_slot;
		logic signed [31:0] result_poc;
	} rsp_t;

	typedef struct packed {
		logic [4:0] flags;
		logic [2:0] progress;
	} meta_t;

	typedef struct packed {
		logic        lt;
		logic [32:0] absd;
	} pocu_t;

	typedef enum logic [1:0] {
		PASS_ALLOC = 2'd0,
		PASS_SEL1  = 2'd1,
		PASS_SEL2  = 2'd2,
		PASS_CLOSE = 2'd3
	} pass_t;

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_SLOT_RD   = 9'b000000010,
		S_SLOT_WR   = 9'b000000100,
		S_SCAN      = 9'b000001000,
		S_SHIFT_RD  = 9'b000010000,
		S_SHIFT_WR  = 9'b000100000,
		S_ALLOC_FIN = 9'b001000000,
		S_SEL_DEC   = 9'b010000000,
		S_SEL_FIN   = 9'b100000000
	} state_t;

endpackage

/* sv/dpb_ram.sv */
// ----------------------------------------------------------------------------
// dpb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/dpb_pocu.sv */
// ----------------------------------------------------------------------------
// dpb_pocu
// Shared POC unit: one subtractor giving signed less-than and distance.
// ----------------------------------------------------------------------------
module dpb_pocu import dpb_pkg::*; (
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output pocu_t              res
);

	logic [32:0] diff;

	assign diff     = {a[31], a} - {b[31], b};
	assign res.lt   = diff[32];
	assign res.absd = diff[32] ? (33'd0 - diff) : diff;

endmodule

/* sv/dpb_output_bumping.sv */
// ----------------------------------------------------------------------------
// dpb_output_bumping
// Picture table with list order: write, allocate, output selection, release
// and closest-POC search, one command item at a time.
// ----------------------------------------------------------------------------
// sequencing: write/release read the entry, then write it; allocate appends at
// once when room allows, else walks the list and, after a full walk, appends;
// allocate reuse shifts every later list entry down and puts the reused slot last;
// select and closest walk the list, which goes through the order RAM and entry
// RAMs and the shared POC unit.
// throughput: one item at a time, next item taken once the result is taken.
// reset: list empty, tune-in count zero, first output pending, registers zero.
// ----------------------------------------------------------------------------
module dpb_output_bumping import dpb_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_wdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	state_t        state_q;
	cmd_t          req_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic [CW-1:0] len_q;
	logic [7:0]    tune_q;
	logic          fop_q;
	logic [3:0]    fd_q, par_q, slack_q;

	pass_t         pass_q;
	logic [CW-1:0] idx_q, hi_q, idx_s1, idx_s2;
	logic          v_s1, v_s2;
	logic [AW-1:0] slot_s2;

	logic          found_q, idr_end_q, flush_q, best_v_q;
	logic [CW-1:0] start_q, end_q, shown_q, k_q;
	logic [AW-1:0] best_slot_q, fin_pos_q, fin_slot_q, hit_slot_q;
	logic signed [31:0] best_poc_q;
	meta_t         best_meta_q;
	logic [32:0]   bestd_q;
	logic          app_q;

	logic          ord_we, meta_we, poc_we;
	logic [AW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
	logic [AW-1:0] meta_waddr, meta_raddr, poc_waddr;
	meta_t         meta_wdata, meta_rdata;
	logic signed [31:0] poc_wdata, poc_rdata;

	pocu_t         pu;
	logic signed [31:0] pu_b;

	logic prog_fin, prog_rec, alloc_hit, sel1_skip, sel1_stop, stop, pass_end;
	logic cand, sel_take;
	logic [7:0] sel_thr;

	assign cmd_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	dpb_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_ord (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	dpb_ram #(.WIDTH($bits(meta_t)), .DEPTH(TABLE_DEPTH)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.raddr(meta_raddr), .rdata(meta_rdata)
	);

	dpb_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_poc (
		.clk(clk), .we(poc_we), .waddr(poc_waddr), .wdata(poc_wdata),
		.raddr(meta_raddr), .rdata(poc_rdata)
	);

	assign pu_b = (pass_q == PASS_CLOSE) ? req_q.poc_value : best_poc_q;

	dpb_pocu u_pocu (.a(poc_rdata), .b(pu_b), .res(pu));

	// per-entry evaluation
	assign prog_fin  = meta_rdata.progress >= PR_FINISHED;
	assign prog_rec  = meta_rdata.progress >= PR_RECON;
	assign alloc_hit = prog_fin && !meta_rdata.flags[FL_LOCK] && !meta_rdata.flags[FL_STILL]
		&& !meta_rdata.flags[FL_REF] && !meta_rdata.flags[FL_NEEDED];
	assign sel1_skip = !meta_rdata.flags[FL_NEEDED] && prog_rec;
	assign sel1_stop = !sel1_skip && (!prog_fin || (meta_rdata.flags[FL_IDR] && found_q));
	assign stop      = v_s2 && (((pass_q == PASS_ALLOC) && alloc_hit) ||
		((pass_q == PASS_SEL1) && sel1_stop));
	assign pass_end  = v_s2 && (stop || (idx_s2 == hi_q - CW'(1)));
	assign cand      = meta_rdata.flags[FL_NEEDED] && prog_fin;

	assign sel_thr  = 8'(req_q.num_reorder) + (fop_q ? 8'(slack_q) : 8'd0);
	assign sel_take = (req_q.command == CMD_SELECT) && best_v_q &&
		(flush_q || (8'(shown_q) > sel_thr));

	always_comb begin
		ord_we     = 1'b0;
		ord_waddr  = k_q[AW-1:0];
		ord_wdata  = ord_rdata;
		ord_raddr  = idx_q[AW-1:0];
		meta_we    = 1'b0;
		meta_waddr = AW'(req_q.slot);
		meta_wdata = meta_rdata;
		meta_raddr = (state_q == S_SCAN) ? ord_rdata : AW'(req_q.slot);
		poc_we     = 1'b0;
		poc_waddr  = AW'(req_q.slot);
		poc_wdata  = req_q.poc_value;
		case (state_q)
			S_SHIFT_RD: begin
				ord_raddr = AW'(k_q + CW'(1));
			end
			S_SHIFT_WR: begin
				ord_we = 1'b1;
			end
			S_SLOT_WR: begin
				meta_we = 1'b1;
				if (req_q.command == CMD_WRITE) begin
					poc_we     = 1'b1;
					meta_wdata = '{flags: {meta_rdata.flags[FL_LOCK], req_q.idr_start,
						req_q.still_referenced, req_q.reference_marked,
						req_q.needed_for_output}, progress: req_q.progress};
				end else begin
					meta_wdata.flags[FL_LOCK] = 1'b0;
				end
			end
			S_ALLOC_FIN: begin
				ord_we     = 1'b1;
				ord_waddr  = fin_pos_q;
				ord_wdata  = fin_slot_q;
				meta_we    = 1'b1;
				meta_waddr = fin_slot_q;
				meta_wdata = '0;
				poc_we     = 1'b1;
				poc_waddr  = fin_slot_q;
				poc_wdata  = '0;
			end
			S_SEL_FIN: begin
				meta_we    = sel_take;
				meta_waddr = best_slot_q;
				meta_wdata = best_meta_q;
				meta_wdata.flags[FL_LOCK]   = 1'b1;
				meta_wdata.flags[FL_NEEDED] = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			len_q       <= '0;
			tune_q      <= '0;
			fop_q       <= 1'b1;
			fd_q        <= '0;
			par_q       <= '0;
			slack_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			pass_q      <= PASS_ALLOC;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_DELAY: fd_q    <= cfg_wdata;
					CFG_PARALLEL:    par_q   <= cfg_wdata;
					CFG_SLACK:       slack_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						req_q   <= cmd;
						rsp_q   <= '{status: ST_NONE, result_slot: '0, result_poc: '0};
						idx_q   <= '0;
						hi_q    <= len_q;
						v_s1    <= 1'b0;
						v_s2    <= 1'b0;
						found_q <= 1'b0;
						start_q <= '0;
						best_v_q <= 1'b0;
						bestd_q <= DIST_INIT;
						case (cmd.command)
							CMD_WRITE, CMD_RELEASE: begin
								if (CW'(cmd.slot) < len_q && 7'(cmd.slot) < 7'(len_q)) begin
									state_q <= S_SLOT_RD;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
							CMD_ALLOC: begin
								if ((8'(len_q) < 8'(cmd.max_pictures) + 8'(fd_q) &&
									len_q < DEPTH_C) || (len_q == '0)) begin
									fin_pos_q  <= AW'(len_q);
									fin_slot_q <= AW'(len_q);
									app_q      <= 1'b1;
									state_q    <= S_ALLOC_FIN;
								end else begin
									pass_q  <= PASS_ALLOC;
									state_q <= S_SCAN;
								end
							end
							CMD_SELECT: begin
								if (len_q == '0) begin
									rsp_valid_q <= 1'b1;
								end else begin
									pass_q  <= PASS_SEL1;
									state_q <= S_SCAN;
								end
							end
							CMD_CLOSEST: begin
								if (len_q == '0) begin
									rsp_valid_q <= 1'b1;
								end else begin
									pass_q  <= PASS_CLOSE;
									state_q <= S_SCAN;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_SLOT_RD: begin
					state_q <= S_SLOT_WR;
				end
				S_SLOT_WR: begin
					rsp_q.status      <= ST_OK;
					rsp_q.result_slot <= req_q.slot;
					rsp_q.result_poc  <= (req_q.command == CMD_WRITE) ? req_q.poc_value
						: poc_rdata;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCAN: begin
					if (pass_end) begin
						v_s1 <= 1'b0;
						v_s2 <= 1'b0;
					end else begin
						v_s1   <= idx_q < hi_q;
						idx_s1 <= idx_q;
						if (idx_q < hi_q) begin
							idx_q <= idx_q + CW'(1);
						end
						v_s2    <= v_s1;
						idx_s2  <= idx_s1;
						slot_s2 <= ord_rdata;
					end
					if (v_s2) begin
						case (pass_q)
							PASS_ALLOC: begin
								if (alloc_hit) begin
									hit_slot_q <= slot_s2;
									k_q        <= idx_s2;
									state_q    <= S_SHIFT_RD;
								end else if (pass_end) begin
									if (len_q < DEPTH_C) begin
										fin_pos_q  <= AW'(len_q);
										fin_slot_q <= AW'(len_q);
										app_q      <= 1'b1;
										state_q    <= S_ALLOC_FIN;
									end else begin
										rsp_q.status <= ST_FULL;
										rsp_valid_q  <= 1'b1;
										state_q      <= S_IDLE;
									end
								end
							end
							PASS_SEL1: begin
								if (sel1_stop) begin
									end_q     <= idx_s2;
									idr_end_q <= meta_rdata.flags[FL_IDR];
								end else begin
									if (!sel1_skip) begin
										if (!found_q && (meta_rdata.flags[FL_IDR] ||
											(!meta_rdata.flags[FL_NEEDED] &&
											!meta_rdata.flags[FL_REF]))) begin
											start_q <= idx_s2;
										end
										if (meta_rdata.flags[FL_NEEDED]) begin
											found_q <= 1'b1;
										end
									end
									if (pass_end) begin
										end_q     <= len_q;
										idr_end_q <= 1'b0;
									end
								end
								if (pass_end) begin
									state_q <= S_SEL_DEC;
								end
							end
							PASS_SEL2: begin
								if (cand) begin
									shown_q <= shown_q + CW'(1);
									if (!best_v_q || pu.lt) begin
										best_v_q    <= 1'b1;
										best_slot_q <= slot_s2;
										best_poc_q  <= poc_rdata;
										best_meta_q <= meta_rdata;
									end
								end
								if (pass_end) begin
									state_q <= S_SEL_FIN;
								end
							end
							default: begin
								if (prog_rec && pu.absd < bestd_q && pu.absd != '0) begin
									bestd_q     <= pu.absd;
									best_v_q    <= 1'b1;
									best_slot_q <= slot_s2;
									best_poc_q  <= poc_rdata;
								end
								if (pass_end) begin
									state_q <= S_SEL_FIN;
								end
							end
						endcase
					end
				end
				S_SHIFT_RD: begin
					if (k_q == len_q - CW'(1)) begin
						fin_pos_q  <= AW'(k_q);
						fin_slot_q <= hit_slot_q;
						app_q      <= 1'b0;
						state_q    <= S_ALLOC_FIN;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					k_q     <= k_q + CW'(1);
					state_q <= S_SHIFT_RD;
				end
				S_ALLOC_FIN: begin
					if (app_q) begin
						len_q <= len_q + CW'(1);
					end
					rsp_q.status      <= ST_OK;
					rsp_q.result_slot <= 5'(fin_slot_q);
					rsp_q.result_poc  <= '0;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SEL_DEC: begin
					if (!found_q) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (tune_q <= 8'(req_q.num_reorder) + 8'(par_q) + 8'd1 &&
						!req_q.flush) begin
						tune_q      <= tune_q + 8'd1;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						flush_q  <= req_q.flush || idr_end_q;
						shown_q  <= '0;
						best_v_q <= 1'b0;
						pass_q   <= PASS_SEL2;
						idx_q    <= start_q;
						hi_q     <= end_q;
						state_q  <= (start_q < end_q) ? S_SCAN : S_SEL_FIN;
					end
				end
				S_SEL_FIN: begin
					if (req_q.command == CMD_SELECT) begin
						if (sel_take) begin
							fop_q             <= 1'b0;
							rsp_q.status      <= ST_OK;
							rsp_q.result_slot <= 5'(best_slot_q);
							rsp_q.result_poc  <= best_poc_q;
						end
					end else if (best_v_q) begin
						rsp_q.status      <= ST_OK;
						rsp_q.result_slot <= 5'(best_slot_q);
						rsp_q.result_poc  <= best_poc_q;
					end
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the picture buffer bumping block: directed and
// random command items are checked against an in-bench model of the table.
// ----------------------------------------------------------------------------
module tb;
	import dpb_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_ready;
	cmd_t       cmd;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [3:0] cfg_wdata;

	dpb_output_bumping dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// table model
	logic signed [31:0] pic_poc [32];
	logic [2:0]         pic_prog [32];
	logic [4:0]         pic_flags [32];
	logic [4:0]         pic_order [32];
	int                 pic_count;
	int                 tune_in;
	bit                 first_out;
	int                 delay_reg, par_reg, slack_reg;

	cmd_t pending_cmds [$];
	rsp_t expected_rsps [$];
	int   mismatches;
	int   send_idle, recv_idle;
	int   hold_cycles;
	bit   hold_go;
	bit   hold_done;
	int   quiet_cycles;

	function automatic rsp_t mk_rsp(logic [1:0] st, int s, logic signed [31:0] p);
		rsp_t r;
		r.status = st;
		r.result_slot = s[4:0];
		r.result_poc = p;
		return r;
	endfunction

	function automatic void queue_cmd(cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	function automatic void clear_pic(int s);
		pic_poc[s] = 0;
		pic_prog[s] = 0;
		pic_flags[s] = 0;
	endfunction

	function automatic rsp_t model_alloc(int maxp);
		int s;
		if (pic_count < maxp + delay_reg && pic_count < 32) begin
			pic_order[pic_count] = pic_count[4:0];
			clear_pic(pic_count);
			pic_count++;
			return mk_rsp(ST_OK, pic_count - 1, 0);
		end
		for (int i = 0; i < pic_count; i++) begin
			s = pic_order[i];
			if (pic_prog[s] < PR_FINISHED || pic_flags[s][FL_STILL] || pic_flags[s][FL_REF] ||
			    pic_flags[s][FL_NEEDED] || pic_flags[s][FL_LOCK])
				continue;
			for (int j = i; j < pic_count - 1; j++)
				pic_order[j] = pic_order[j + 1];
			pic_order[pic_count - 1] = s[4:0];
			clear_pic(s);
			return mk_rsp(ST_OK, s, 0);
		end
		if (pic_count < 32) begin
			pic_order[pic_count] = pic_count[4:0];
			clear_pic(pic_count);
			pic_count++;
			return mk_rsp(ST_OK, pic_count - 1, 0);
		end
		return mk_rsp(ST_FULL, 0, 0);
	endfunction

	function automatic rsp_t model_select(int reorder, bit flush);
		int s, start_i, end_i, shown, best;
		bit found;
		start_i = 0;
		end_i = pic_count;
		shown = 0;
		best = -1;
		found = 0;
		if (pic_count == 0)
			return mk_rsp(ST_NONE, 0, 0);
		for (int i = 0; i < pic_count; i++) begin
			s = pic_order[i];
			if (!pic_flags[s][FL_NEEDED] && pic_prog[s] >= PR_RECON)
				continue;
			if (pic_prog[s] < PR_FINISHED) begin
				end_i = i;
				break;
			end
			if (pic_flags[s][FL_IDR]) begin
				if (!found) start_i = i;
				else begin
					end_i = i;
					break;
				end
			end
			if (pic_flags[s][FL_NEEDED]) found = 1;
			if (!found && !pic_flags[s][FL_REF]) start_i = i;
		end
		if (!found)
			return mk_rsp(ST_NONE, 0, 0);
		if (tune_in <= reorder + par_reg + 1 && !flush) begin
			tune_in = (tune_in + 1) & 8'hff;
			return mk_rsp(ST_NONE, 0, 0);
		end
		if (end_i < pic_count && pic_flags[pic_order[end_i]][FL_IDR])
			flush = 1;
		if (!flush)
			for (int i = start_i; i < end_i; i++) begin
				s = pic_order[i];
				if (pic_flags[s][FL_NEEDED] && pic_prog[s] >= PR_FINISHED) shown++;
			end
		if (flush || shown > reorder + (first_out ? slack_reg : 0))
			for (int i = start_i; i < end_i; i++) begin
				s = pic_order[i];
				if (pic_flags[s][FL_NEEDED] && pic_prog[s] >= PR_FINISHED &&
				    (best < 0 || pic_poc[s] < pic_poc[best]))
					best = s;
			end
		if (best < 0)
			return mk_rsp(ST_NONE, 0, 0);
		first_out = 0;
		pic_flags[best][FL_LOCK] = 1;
		pic_flags[best][FL_NEEDED] = 0;
		return mk_rsp(ST_OK, best, pic_poc[best]);
	endfunction

	function automatic rsp_t model_closest(logic signed [31:0] lost);
		longint bestd, d;
		int best, s;
		bestd = 64'sd2147483647;
		best = -1;
		for (int i = 0; i < pic_count; i++) begin
			s = pic_order[i];
			d = longint'(pic_poc[s]) - longint'(lost);
			if (d < 0) d = -d;
			if (pic_prog[s] >= PR_RECON && d < bestd && d != 0) begin
				bestd = d;
				best = s;
			end
		end
		if (best < 0)
			return mk_rsp(ST_NONE, 0, 0);
		return mk_rsp(ST_OK, best, pic_poc[best]);
	endfunction

	function automatic rsp_t model_step(cmd_t c);
		case (c.command)
			CMD_WRITE: begin
				if (c.slot >= pic_count) return mk_rsp(ST_NONE, 0, 0);
				pic_poc[c.slot] = c.poc_value;
				pic_prog[c.slot] = c.progress;
				pic_flags[c.slot] = {pic_flags[c.slot][FL_LOCK], c.idr_start,
					c.still_referenced, c.reference_marked, c.needed_for_output};
				return mk_rsp(ST_OK, c.slot, c.poc_value);
			end
			CMD_ALLOC: return model_alloc(c.max_pictures);
			CMD_SELECT: return model_select(c.num_reorder, c.flush);
			CMD_RELEASE: begin
				if (c.slot >= pic_count) return mk_rsp(ST_NONE, 0, 0);
				pic_flags[c.slot][FL_LOCK] = 0;
				return mk_rsp(ST_OK, c.slot, pic_poc[c.slot]);
			end
			CMD_CLOSEST: return model_closest(c.poc_value);
			default: return mk_rsp(ST_NONE, 0, 0);
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int r;
		c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
		r = $urandom_range(99);
		if (r < 40) c.command = CMD_WRITE;
		else if (r < 60) c.command = CMD_ALLOC;
		else if (r < 82) c.command = CMD_SELECT;
		else if (r < 90) c.command = CMD_RELEASE;
		else if (r < 97) c.command = CMD_CLOSEST;
		else c.command = 3'($urandom_range(7, 5));
		if ($urandom_range(9) < 8) c.slot = 5'($urandom_range(pic_count > 0 ? pic_count + 1 : 2));
		if ($urandom_range(3) != 0) c.poc_value = $signed(32'($urandom_range(60))) - 20;
		if ($urandom_range(9) < 8) c.progress = $urandom_range(9) < 6 ? PR_FINISHED : 3'($urandom_range(7));
		if ($urandom_range(3) != 0) c.num_reorder = 5'($urandom_range(3));
		c.flush = $urandom_range(5) == 0;
		c.idr_start = $urandom_range(7) == 0;
		c.max_pictures = 6'($urandom_range(32, 1));
		if ($urandom_range(3) != 0) c.max_pictures = 6'($urandom_range(8, 1));
		return c;
	endfunction

	function automatic cmd_t dir_cmd(logic [2:0] op, int s, logic signed [31:0] p,
		logic [2:0] pr, logic [3:0] fl, int ro, bit fs, int mp);
		cmd_t c;
		c.command = op;
		c.slot = s[4:0];
		c.poc_value = p;
		c.progress = pr;
		{c.idr_start, c.still_referenced, c.reference_marked, c.needed_for_output} = fl;
		c.num_reorder = ro[4:0];
		c.flush = fs;
		c.max_pictures = mp[5:0];
		return c;
	endfunction

	task automatic write_reg(logic [1:0] idx, int v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v[3:0];
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_FRAME_DELAY) delay_reg = v;
		else if (idx == CFG_PARALLEL) par_reg = v;
		else if (idx == CFG_SLACK) slack_reg = v;
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 0;
			cmd <= '0;
		end else if (!cmd_valid || cmd_ready) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1;
			end else begin
				cmd_valid <= 0;
			end
		end
	end

	// long receiver hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done <= 0;
		end else if (hold_go && !hold_done) begin
			if (hold_cycles == 3000)
				hold_done <= 1;
			else
				hold_cycles <= hold_cycles + 1;
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_r;
		if (!arst_n) begin
			rsp_ready <= 0;
			pic_count = 0;
			tune_in = 0;
			first_out = 1;
		end else begin
			if (cmd_valid && cmd_ready)
				expected_rsps.insert(expected_rsps.size(), model_step(cmd));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected item %p", rsp);
				end else begin
					exp_r = expected_rsps.pop_front();
					if (rsp.status !== exp_r.status || rsp.result_slot !== exp_r.result_slot ||
					    rsp.result_poc !== exp_r.result_poc) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", exp_r, rsp);
					end
				end
			end
			if (hold_go && !hold_done)
				rsp_ready <= 0;
			else
				rsp_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_wdata = 0;
		send_idle = 0;
		recv_idle = 0;
		hold_go = 0;
		delay_reg = 0;
		par_reg = 0;
		slack_reg = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		write_reg(CFG_FRAME_DELAY, 0);
		write_reg(CFG_PARALLEL, 0);
		write_reg(CFG_SLACK, 0);
		write_reg(2'd3, 9);
		// directed part
		queue_cmd(dir_cmd(CMD_SELECT, 0, 0, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_WRITE, 0, 5, 5, 4'hf, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_RELEASE, 3, 0, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_ALLOC, 0, 0, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_ALLOC, 0, 0, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_ALLOC, 0, 0, 0, 0, 0, 0, 2));
		queue_cmd(dir_cmd(CMD_WRITE, 0, 32'sh7fffffff, 5, 4'h1, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_WRITE, 1, 32'sh80000000, 7, 4'h1, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_WRITE, 2, -3, 6, 4'h9, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_CLOSEST, 0, 32'sh80000000, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_CLOSEST, 0, -3, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_CLOSEST, 0, 32'sh7fffffff, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_SELECT, 0, 0, 0, 0, 31, 0, 1));
		queue_cmd(dir_cmd(CMD_SELECT, 0, 0, 0, 0, 0, 1, 1));
		queue_cmd(dir_cmd(CMD_SELECT, 0, 0, 0, 0, 0, 1, 1));
		queue_cmd(dir_cmd(CMD_RELEASE, 0, 0, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_WRITE, 1, 9, 5, 4'h0, 0, 0, 1));
		queue_cmd(dir_cmd(CMD_ALLOC, 0, 0, 0, 0, 0, 0, 32));
		queue_cmd(dir_cmd(CMD_ALLOC, 0, 0, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(3'd5, 0, 0, 0, 0, 0, 0, 1));
		queue_cmd(dir_cmd(3'd7, 31, -1, 7, 4'hf, 31, 1, 63));
		wait_drained();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 22; recv_idle = 46; end
				2: begin send_idle = 46; recv_idle = 22; end
				4: begin send_idle = 0; recv_idle = 0; end
				default: ;
			endcase
			write_reg(CFG_FRAME_DELAY, ph == 4 ? 15 : $urandom_range(15));
			write_reg(CFG_PARALLEL, ph == 1 ? 15 : (ph == 3 ? 0 : $urandom_range(15)));
			write_reg(CFG_SLACK, ph == 2 ? 15 : (ph == 0 ? 0 : $urandom_range(15)));
			for (int n = 0; n < 300; n++)
				queue_cmd(rand_cmd());
			if (ph == 1) begin
				hold_go = 1;
			end
			wait_drained();
		end
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
